// ===== hdl/fgs_pkg.sv =====
// Package with shared types, rule tables and constants of the fuzzy gain scheduler.
`default_nettype none
package fgs_pkg;

    localparam int ErrW  = 12;
    localparam int ChgW  = 11;
    localparam int GainW = 22;
    localparam int QuoW  = 21;
    localparam int DenW  = 28;
    localparam int MagW  = 25;

    localparam logic [16:0] W_ONE = 17'd65536;
    localparam logic [9:0]  P_UNIT = 10'd1000;

    typedef struct packed {
        logic [2:0] seg;
        logic [7:0] delta;
    } t_fz;

    localparam logic signed [11:0] E_PEAK [0:6] = '{
        -12'sd400, -12'sd200, -12'sd60, 12'sd0, 12'sd60, 12'sd200, 12'sd400
    };
    localparam logic signed [11:0] C_PEAK [0:4] = '{
        -12'sd8, -12'sd3, 12'sd0, 12'sd3, 12'sd8
    };

    // Output labels: 0 NB, 1 NM, 2 NS, 3 ZO, 4 PS, 5 PM, 6 PB.
    localparam logic [2:0] TAB_P [0:6][0:4] = '{
        '{3'd5, 3'd4, 3'd2, 3'd1, 3'd0},
        '{3'd4, 3'd3, 3'd2, 3'd1, 3'd0},
        '{3'd6, 3'd4, 3'd3, 3'd2, 3'd0},
        '{3'd6, 3'd3, 3'd3, 3'd3, 3'd0},
        '{3'd6, 3'd4, 3'd3, 3'd2, 3'd0},
        '{3'd4, 3'd3, 3'd2, 3'd1, 3'd0},
        '{3'd5, 3'd4, 3'd2, 3'd1, 3'd0}
    };
    localparam logic [2:0] TAB_D [0:6][0:4] = '{
        '{3'd5, 3'd6, 3'd3, 3'd3, 3'd2},
        '{3'd4, 3'd5, 3'd3, 3'd6, 3'd6},
        '{3'd3, 3'd4, 3'd3, 3'd3, 3'd2},
        '{3'd2, 3'd3, 3'd3, 3'd3, 3'd2},
        '{3'd2, 3'd3, 3'd3, 3'd4, 3'd3},
        '{3'd6, 3'd6, 3'd3, 3'd5, 3'd4},
        '{3'd2, 3'd3, 3'd3, 3'd6, 3'd5}
    };
    localparam logic signed [5:0] SING_P [0:7] = '{
        -6'sd15, -6'sd7, -6'sd5, 6'sd0, 6'sd1, 6'sd5, 6'sd10, 6'sd0
    };
    localparam logic signed [5:0] SING_D [0:7] = '{
        -6'sd8, -6'sd8, -6'sd9, 6'sd0, 6'sd1, 6'sd7, 6'sd20, 6'sd0
    };

    // Segment and distance to its upper peak, after clamping to the outer peaks.
    function automatic t_fz fuzz_e(input logic signed [11:0] x);
        logic signed [11:0] xs;
        logic signed [11:0] diff;
        t_fz f;
        xs = x;
        if (xs < E_PEAK[0]) xs = E_PEAK[0];
        if (xs > E_PEAK[6]) xs = E_PEAK[6];
        f.seg = 3'd6;
        for (int k = 5; k >= 1; k--) begin
            if (xs <= E_PEAK[k]) f.seg = 3'(k);
        end
        diff = E_PEAK[f.seg] - xs;
        f.delta = diff[7:0];
        return f;
    endfunction

    function automatic t_fz fuzz_c(input logic signed [11:0] x);
        logic signed [11:0] xs;
        logic signed [11:0] diff;
        t_fz f;
        xs = x;
        if (xs < C_PEAK[0]) xs = C_PEAK[0];
        if (xs > C_PEAK[4]) xs = C_PEAK[4];
        f.seg = 3'd4;
        for (int k = 3; k >= 1; k--) begin
            if (xs <= C_PEAK[k]) f.seg = 3'(k);
        end
        diff = C_PEAK[f.seg] - xs;
        f.delta = diff[7:0];
        return f;
    endfunction

    function automatic logic [7:0] e_width(input logic [2:0] seg);
        logic [7:0] w;
        unique case (seg)
            3'd1, 3'd6: w = 8'd200;
            3'd2, 3'd5: w = 8'd140;
            default:    w = 8'd60;
        endcase
        return w;
    endfunction

    function automatic logic [7:0] c_width(input logic [2:0] seg);
        logic [7:0] w;
        unique case (seg)
            3'd1, 3'd4: w = 8'd5;
            default:    w = 8'd3;
        endcase
        return w;
    endfunction

    // floor(2^48 / width) for each segment width.
    function automatic logic [46:0] e_recip(input logic [2:0] seg);
        logic [46:0] k;
        unique case (seg)
            3'd1, 3'd6: k = 47'd1407374883553;
            3'd2, 3'd5: k = 47'd2010535547933;
            default:    k = 47'd4691249611844;
        endcase
        return k;
    endfunction

    function automatic logic [46:0] c_recip(input logic [2:0] seg);
        logic [46:0] k;
        unique case (seg)
            3'd1, 3'd4: k = 47'd56294995342131;
            default:    k = 47'd93824992236885;
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/fuzzy_gain_scheduler.sv =====
// Top level of the fuzzy gain scheduler: fuzzification, rule stages and divider pipeline.
//
//  Channel   Direction  Beat contents
//  s (in)    slave      tdata[11:0] error, tdata[22:12] error_change, tdata[23] zero
//  m (out)   master     tdata[21:0] gain (Q.16), tdata[23:22] zero
//  APB       slave      register 0 at address 0: mode (bit 0)
//
// One beat enters per cycle while o_s_tready is high; each result passes through
// 8 fuzzification and rule stages, then 7 divider stages of three quotient bits each.
// Every stage holds while the stage after it is full and stalled, so a stall on
// the output fills the bubbles first and only then deasserts o_s_tready.
// Synchronous reset clears all valid bits and sets mode to 0.
`default_nettype none
module fuzzy_gain_scheduler (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [23:0] i_s_tdata,   // [11:0] error, [22:12] error_change
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [23:0] o_m_tdata,   // [21:0] gain
    input  wire         i_psel,
    input  wire         i_penable,
    input  wire         i_pwrite,
    input  wire  [2:0]  i_paddr,
    input  wire  [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);

    localparam int NSt = 15;

    logic            r_mode;
    logic [NSt-1:0]  r_vld;
    logic [NSt-1:0]  en;

    // Configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (i_psel && i_penable && i_pwrite && !i_paddr[2]) begin
            r_mode <= i_pwdata[0];
        end
    end
    assign o_pready = 1'b1;
    assign o_prdata = {31'd0, i_paddr[2] ? 1'b0 : r_mode};

    // A stage may load when it is empty or the next stage loads too.
    always_comb begin
        en[NSt-1] = !r_vld[NSt-1] || i_m_tready;
        for (int k = NSt - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end
    assign o_s_tready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) r_vld[0] <= i_s_tvalid;
            for (int k = 1; k < NSt; k++) begin
                if (en[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // Stage 0: input register
    logic signed [11:0] r0_e;
    logic signed [10:0] r0_c;
    logic               r0_mode;
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r0_e    <= i_s_tdata[11:0];
            r0_c    <= i_s_tdata[22:12];
            r0_mode <= r_mode;
        end
    end

    // Stage 1: error_change negated in mode 0, clamp, segment search and distance to the upper peak
    logic signed [11:0] c_ext;
    fgs_pkg::t_fz       fz_e, fz_c;
    assign c_ext = r0_mode ? 12'(r0_c) : (12'sd0 - 12'(r0_c));
    assign fz_e  = fgs_pkg::fuzz_e(r0_e);
    assign fz_c  = fgs_pkg::fuzz_c(c_ext);

    fgs_pkg::t_fz r1_e, r1_c;
    logic         r1_mode;
    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r1_e    <= fz_e;
            r1_c    <= fz_c;
            r1_mode <= r0_mode;
        end
    end

    // Stage 2: reciprocal multiply gives the weight or one less
    logic [54:0] prod_e, prod_c;
    assign prod_e = 55'(r1_e.delta) * 55'(fgs_pkg::e_recip(r1_e.seg));
    assign prod_c = 55'(r1_c.delta) * 55'(fgs_pkg::c_recip(r1_c.seg));

    fgs_pkg::t_fz r2_e, r2_c;
    logic [16:0]  r2_qe, r2_qc;
    logic         r2_mode;
    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r2_e    <= r1_e;
            r2_c    <= r1_c;
            r2_qe   <= prod_e[48:32];
            r2_qc   <= prod_c[48:32];
            r2_mode <= r1_mode;
        end
    end

    // Stage 3: remainder check corrects the estimate
    logic [7:0]  wd_e, wd_c;
    logic [24:0] rem_e, rem_c;
    assign wd_e  = fgs_pkg::e_width(r2_e.seg);
    assign wd_c  = fgs_pkg::c_width(r2_c.seg);
    assign rem_e = {1'b0, r2_e.delta, 16'd0} - 25'(r2_qe) * 25'(wd_e);
    assign rem_c = {1'b0, r2_c.delta, 16'd0} - 25'(r2_qc) * 25'(wd_c);

    logic [2:0]  r3_er, r3_cr;
    logic [16:0] r3_pe0, r3_pc0;
    logic        r3_mode;
    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r3_er   <= r2_e.seg;
            r3_cr   <= r2_c.seg;
            r3_pe0  <= (rem_e >= 25'(wd_e)) ? r2_qe + 17'd1 : r2_qe;
            r3_pc0  <= (rem_c >= 25'(wd_c)) ? r2_qc + 17'd1 : r2_qc;
            r3_mode <= r2_mode;
        end
    end

    // Stage 4: rule labels and strengths
    logic [16:0] pe1, pc1;
    logic [2:0]  er0, cr0;
    logic [2:0]  lab4 [0:3];
    logic [16:0] w4   [0:3];
    assign pe1 = fgs_pkg::W_ONE - r3_pe0;
    assign pc1 = fgs_pkg::W_ONE - r3_pc0;
    assign er0 = r3_er - 3'd1;
    assign cr0 = r3_cr - 3'd1;

    always_comb begin
        if (r3_mode) begin
            lab4[0] = fgs_pkg::TAB_D[er0][cr0];
            lab4[1] = fgs_pkg::TAB_D[r3_er][cr0];
            lab4[2] = fgs_pkg::TAB_D[er0][r3_cr];
            lab4[3] = fgs_pkg::TAB_D[r3_er][r3_cr];
        end else begin
            lab4[0] = fgs_pkg::TAB_P[er0][cr0];
            lab4[1] = fgs_pkg::TAB_P[r3_er][cr0];
            lab4[2] = fgs_pkg::TAB_P[er0][r3_cr];
            lab4[3] = fgs_pkg::TAB_P[r3_er][r3_cr];
        end
        w4[0] = (r3_pe0 <= r3_pc0) ? r3_pe0 : r3_pc0;
        w4[1] = (pe1 <= r3_pc0) ? pe1 : r3_pc0;
        w4[2] = (r3_pe0 <= pc1) ? r3_pe0 : pc1;
        w4[3] = (pe1 <= pc1) ? pe1 : pc1;
    end

    logic [2:0]  r4_lab [0:3];
    logic [16:0] r4_w   [0:3];
    logic        r4_mode;
    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r4_lab  <= lab4;
            r4_w    <= w4;
            r4_mode <= r3_mode;
        end
    end

    // Stage 5: among rules with the same label, keep only the strongest (later on a tie).
    logic [16:0] w5 [0:3];
    always_comb begin
        w5 = r4_w;
        for (int i = 0; i < 3; i++) begin
            for (int j = i + 1; j < 4; j++) begin
                if (r4_lab[i] == r4_lab[j]) begin
                    if (w5[i] > w5[j]) w5[j] = '0;
                    else               w5[i] = '0;
                end
            end
        end
    end

    logic [2:0]  r5_lab [0:3];
    logic [16:0] r5_w   [0:3];
    logic        r5_mode;
    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r5_lab  <= r4_lab;
            r5_w    <= w5;
            r5_mode <= r4_mode;
        end
    end

    // Stage 6: weighted singletons and weight sum
    logic signed [23:0] prod6 [0:3];
    logic [18:0]        dsum6;
    always_comb begin
        dsum6 = '0;
        for (int i = 0; i < 4; i++) begin
            prod6[i] = $signed({1'b0, r5_w[i]})
                     * (r5_mode ? fgs_pkg::SING_D[r5_lab[i]] : fgs_pkg::SING_P[r5_lab[i]]);
            dsum6 = dsum6 + 19'(r5_w[i]);
        end
    end

    logic signed [23:0] r6_p [0:3];
    logic [18:0]        r6_dsum;
    logic               r6_mode;
    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r6_p    <= prod6;
            r6_dsum <= dsum6;
            r6_mode <= r5_mode;
        end
    end

    // Stage 7: numerator sum, denominator (scaled by P_UNIT in mode 0), sign and magnitude
    logic signed [25:0] num7;
    logic [27:0]        den7;
    assign num7 = 26'(r6_p[0]) + 26'(r6_p[1]) + 26'(r6_p[2]) + 26'(r6_p[3]);
    assign den7 = r6_mode ? 28'(r6_dsum) : 28'(r6_dsum) * 28'(fgs_pkg::P_UNIT);

    logic [fgs_pkg::MagW-1:0] r7_mag;
    logic [fgs_pkg::DenW-1:0] r7_den;
    logic                     r7_neg;
    always_ff @(posedge i_clk) begin
        if (en[7]) begin
            r7_neg <= num7[25];
            r7_mag <= num7[25] ? 25'(26'sd0 - num7) : num7[24:0];
            r7_den <= den7;
        end
    end

    // Stages 8 to 14: divider
    logic [fgs_pkg::GainW-1:0] gain;
    fgs_div u_div (
        .i_clk  (i_clk),
        .i_en   (en[14:8]),
        .i_mag  (r7_mag),
        .i_den  (r7_den),
        .i_neg  (r7_neg),
        .o_gain (gain)
    );

    assign o_m_tvalid = r_vld[NSt-1];
    assign o_m_tdata  = {2'b00, gain};

    a_ready_when_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[NSt-1] |-> o_s_tready)
        else $error("input stalled although the output stage is empty");

    a_segments: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1] |-> (r1_e.seg >= 3'd1 && r1_e.seg <= 3'd6
                      && r1_c.seg >= 3'd1 && r1_c.seg <= 3'd4))
        else $error("segment index out of range");

    a_weights: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[3] |-> (r3_pe0 <= fgs_pkg::W_ONE && r3_pc0 <= fgs_pkg::W_ONE))
        else $error("membership weight above one");

    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[7] |-> (r7_den != '0))
        else $error("zero weight sum reached the divider");

endmodule
`default_nettype wire

// ===== hdl/fgs_div.sv =====
// Pipelined restoring divider producing the signed gain, three quotient bits per stage.
`default_nettype none
module fgs_div (
    input  wire                          i_clk,
    input  wire  [6:0]                   i_en,
    input  wire  [fgs_pkg::MagW-1:0]     i_mag,
    input  wire  [fgs_pkg::DenW-1:0]     i_den,
    input  wire                          i_neg,
    output logic [fgs_pkg::GainW-1:0]    o_gain
);

    logic [fgs_pkg::DenW-1:0]  r_rem [0:5];
    logic [fgs_pkg::QuoW-1:0]  r_quo [0:5];
    logic [fgs_pkg::MagW-1:0]  r_mag [0:5];
    logic [fgs_pkg::DenW-1:0]  r_den [0:5];
    logic                      r_neg [0:5];
    logic [fgs_pkg::GainW-1:0] r_gain;

    for (genvar j = 0; j < 7; j++) begin : g_st
        logic [fgs_pkg::DenW-1:0] rem_in;
        logic [fgs_pkg::QuoW-1:0] quo_in;
        logic [fgs_pkg::MagW-1:0] mag_in;
        logic [fgs_pkg::DenW-1:0] den_in;
        logic                     neg_in;
        logic [fgs_pkg::DenW-1:0] n_rem;
        logic [fgs_pkg::QuoW-1:0] n_quo;

        if (j == 0) begin : g_src0
            // The quotient fits in 21 bits, so the top of the dividend is below the divisor.
            assign rem_in = fgs_pkg::DenW'(i_mag >> 5);
            assign quo_in = '0;
            assign mag_in = i_mag;
            assign den_in = i_den;
            assign neg_in = i_neg;
        end else begin : g_srcn
            assign rem_in = r_rem[j-1];
            assign quo_in = r_quo[j-1];
            assign mag_in = r_mag[j-1];
            assign den_in = r_den[j-1];
            assign neg_in = r_neg[j-1];
        end

        always_comb begin
            logic [40:0] dvd;
            logic [28:0] sh;
            dvd   = {mag_in, 16'd0};
            n_rem = rem_in;
            n_quo = quo_in;
            for (int t = 0; t < 3; t++) begin
                sh = {n_rem, dvd[20 - 3*j - t]};
                if (sh >= {1'b0, den_in}) begin
                    sh = sh - {1'b0, den_in};
                    n_quo[20 - 3*j - t] = 1'b1;
                end
                n_rem = sh[fgs_pkg::DenW-1:0];
            end
        end

        if (j < 6) begin : g_mid
            always_ff @(posedge i_clk) begin
                if (i_en[j]) begin
                    r_rem[j] <= n_rem;
                    r_quo[j] <= n_quo;
                    r_mag[j] <= mag_in;
                    r_den[j] <= den_in;
                    r_neg[j] <= neg_in;
                end
            end
        end else begin : g_last
            always_ff @(posedge i_clk) begin
                if (i_en[j]) begin
                    r_gain <= neg_in ? (fgs_pkg::GainW'(0) - {1'b0, n_quo})
                                     : {1'b0, n_quo};
                end
            end
        end
    end

    assign o_gain = r_gain;

endmodule
`default_nettype wire
